// File: src/rdc_pkg.sv
// Package for the radix digit converter: sizes, types and the digit alphabet.
`default_nettype none
package rdc_pkg;

    // Digits produced per item and depth of the digit stack
    localparam int DIGITS      = 32;
    localparam int STACK_DEPTH = 32;
    // Digits that survive the stack: pushes beyond the depth are dropped
    localparam int PRODUCED    = (DIGITS < STACK_DEPTH) ? DIGITS : STACK_DEPTH;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int KIND_W      = 2;
    localparam int NUM_W       = 31;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;

    // Radix select codes
    localparam logic [KIND_W-1:0] KIND_BIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OCT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEX = 2'd2;
    localparam logic [KIND_W-1:0] KIND_B36 = 2'd3;

    // Reciprocal of 9 scaled by 2^33, rounded up; exact for dividends below 2^29
    localparam int             RECIP_SHIFT = 33;
    localparam logic [29:0]    RECIP9      = 30'd954437177;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_READ,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture a new item, clear the digit count
        logic div;      // register the quotient of the working value
        logic push;     // store the remainder, advance the working value
        logic set_top;  // point the pop index at the top of the stack
        logic emit;     // load the output register, step the pop index down
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cnt_last;  // the digit being pushed is the final one
        logic idx_zero;  // the pop index is at the bottom of the stack
        logic out_free;  // the output register can take a new character
    } t_dp_status;

    // Map a digit value 0..35 to its ASCII code
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < DIGIT_W'(10)) begin
            r = CHAR_W'(48) + CHAR_W'(d);
        end else begin
            r = CHAR_W'(55) + CHAR_W'(d);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/rdc_dp.sv
// Datapath: divide step, digit stack memory, pop index and output register.
`default_nettype none
module rdc_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rdc_pkg::t_dp_cmd              i_cmd,
    output rdc_pkg::t_dp_status                o_status,
    input  wire logic [rdc_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [rdc_pkg::NUM_W-1:0]     i_number,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [rdc_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                               o_last
);

    logic [rdc_pkg::KIND_W-1:0]  r_kind;
    logic [rdc_pkg::NUM_W-1:0]   r_n;
    logic [rdc_pkg::NUM_W-1:0]   r_q;
    logic [rdc_pkg::IDX_W-1:0]   r_cnt;
    logic [rdc_pkg::IDX_W-1:0]   r_idx;
    logic [rdc_pkg::IDX_W-1:0]   n_idx;
    logic [rdc_pkg::DIGIT_W-1:0] r_rd_data;
    logic                        r_valid;
    logic [rdc_pkg::CHAR_W-1:0]  r_char;
    logic                        r_last;

    logic [rdc_pkg::DIGIT_W-1:0] mem [rdc_pkg::STACK_DEPTH];

    logic [58:0]                 w_prod;
    logic [rdc_pkg::NUM_W-1:0]   n_q;
    logic [rdc_pkg::NUM_W-1:0]   w_qr;
    logic [rdc_pkg::NUM_W-1:0]   w_rem;

    // Divide by 36 as (n / 4) / 9 through the scaled reciprocal
    assign w_prod = 59'(r_n[rdc_pkg::NUM_W-1:2]) * 59'(rdc_pkg::RECIP9);

    // Select the quotient for the radix
    always_comb begin
        case (r_kind)
            rdc_pkg::KIND_BIN: n_q = r_n >> 1;
            rdc_pkg::KIND_OCT: n_q = r_n >> 3;
            rdc_pkg::KIND_HEX: n_q = r_n >> 4;
            default:           n_q = rdc_pkg::NUM_W'(w_prod[58:rdc_pkg::RECIP_SHIFT]);
        endcase
    end

    // Rebuild quotient times radix with shifts, take the remainder
    always_comb begin
        case (r_kind)
            rdc_pkg::KIND_BIN: w_qr = r_q << 1;
            rdc_pkg::KIND_OCT: w_qr = r_q << 3;
            rdc_pkg::KIND_HEX: w_qr = r_q << 4;
            default:           w_qr = (r_q << 5) + (r_q << 2);
        endcase
        w_rem = r_n - w_qr;
    end

    // Hold item, quotient and push count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_n    <= i_number;
        end else if (i_cmd.push) begin
            r_n    <= r_q;
        end
        if (i_cmd.div) begin
            r_q <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.push) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Pop index
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.set_top) begin
            n_idx = rdc_pkg::IDX_W'(rdc_pkg::PRODUCED - 1);
        end else if (i_cmd.emit) begin
            n_idx = r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // Digit stack: write on push, registered read at the pop index
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_cnt] <= w_rem[rdc_pkg::DIGIT_W-1:0];
        end
        r_rd_data <= mem[n_idx];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char <= rdc_pkg::to_ascii(r_rd_data);
            r_last <= (r_idx == '0);
        end
    end

    assign o_status.cnt_last = (r_cnt == rdc_pkg::IDX_W'(rdc_pkg::PRODUCED - 1));
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.out_free = !r_valid || !i_stall;

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

endmodule
`default_nettype wire

// File: src/rdc_ctrl.sv
// Controller: sequences divide, push, stack read and character transfer.
`default_nettype none
module rdc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire rdc_pkg::t_dp_status  i_status,
    output rdc_pkg::t_dp_cmd          o_cmd
);

    rdc_pkg::t_state r_state;
    rdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                if (i_valid) n_state = rdc_pkg::S_DIV;
            end
            rdc_pkg::S_DIV: begin
                n_state = rdc_pkg::S_PUSH;
            end
            rdc_pkg::S_PUSH: begin
                n_state = i_status.cnt_last ? rdc_pkg::S_READ : rdc_pkg::S_DIV;
            end
            rdc_pkg::S_READ: begin
                n_state = rdc_pkg::S_EMIT;
            end
            rdc_pkg::S_EMIT: begin
                if (i_status.out_free && i_status.idx_zero) n_state = rdc_pkg::S_IDLE;
            end
            default: n_state = rdc_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            rdc_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
            end
            rdc_pkg::S_PUSH: begin
                o_cmd.push    = 1'b1;
                o_cmd.set_top = i_status.cnt_last;
            end
            rdc_pkg::S_READ: begin
                o_cmd = '0;
            end
            rdc_pkg::S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: src/radix_digit_converter_top.sv
// Top level of the radix digit converter: controller plus datapath.
// Sequence: each digit passes the divide state and then the push state; after the
// last push, one stack read state and the output load offer the first character.
// A new item is taken only in idle, once every character of the last one is sent;
// characters are drained one a cycle while the output is not stalled.
// Reset: synchronous, active low; returns to idle and drops the output valid.
`default_nettype none
module radix_digit_converter_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [rdc_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [rdc_pkg::NUM_W-1:0]     i_number,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [rdc_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                               o_last
);

    rdc_pkg::t_dp_cmd    w_cmd;
    rdc_pkg::t_dp_status w_status;

    rdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rdc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_kind       (i_kind),
        .i_number     (i_number),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
